### hw/rtl/tfba_pkg.sv
// shared types, constants and codes of the two-class fifo burst arbiter
package tfba_pkg;

    // fixed field widths
    localparam int TAG_WIDTH     = 16;
    localparam int LIMIT_WIDTH   = 4;
    localparam int WAITING_WIDTH = 6;

    // defaults
    localparam int QUEUE_DEPTH_DEFAULT = 16;
    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 4'd5;

    // result status codes
    typedef enum logic [1:0] {
        ST_ENQUEUED = 2'd0,
        ST_DROPPED  = 2'd1,
        ST_SERVED   = 2'd2,
        ST_NONE     = 2'd3
    } t_status;

    // decoded operation carried from front to back
    typedef enum logic [1:0] {
        OP_ENQ_NORMAL = 2'd0,
        OP_ENQ_URGENT = 2'd1,
        OP_CALL       = 2'd2
    } t_op;

    // input word
    typedef struct packed {
        logic                 cmd;
        logic [TAG_WIDTH-1:0] item_tag;
        logic                 is_urgent;
    } t_in_word;

    // result word
    typedef struct packed {
        t_status                  status;
        logic [TAG_WIDTH-1:0]     served_tag;
        logic                     served_urgent;
        logic [WAITING_WIDTH-1:0] total_waiting;
    } t_out_word;

    // classified command word between front and back
    typedef struct packed {
        t_op                  op;
        logic [TAG_WIDTH-1:0] tag;
    } t_cmd_word;

endpackage

### hw/rtl/tfba_front.sv
// front end: accepts input words, classifies them and buffers two commands
module tfba_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  tfba_pkg::t_in_word   i_in,
    output tfba_pkg::t_cmd_word  o_cmd,
    output logic                 o_cmd_valid,
    input  logic                 i_cmd_ready
);

    tfba_pkg::t_cmd_word r_slot [2];
    logic                r_wr_ptr;
    logic                r_rd_ptr;
    logic [1:0]          r_count;
    logic [1:0]          n_count;
    tfba_pkg::t_cmd_word w_cmd;
    logic                w_push;
    logic                w_pop;

    // classify the incoming word
    always_comb begin
        w_cmd.tag = i_in.item_tag;
        if (i_in.cmd) begin
            w_cmd.op = tfba_pkg::OP_CALL;
        end else if (i_in.is_urgent) begin
            w_cmd.op = tfba_pkg::OP_ENQ_URGENT;
        end else begin
            w_cmd.op = tfba_pkg::OP_ENQ_NORMAL;
        end
    end

    // handshakes
    assign full        = (r_count == 2'd2);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_slot[r_rd_ptr];
    assign w_push      = push && !full;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    // occupancy
    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (!w_push && w_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    // command slots
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

### hw/rtl/tfba_back.sv
// back end: the two tag stores, burst counter and arbitration
module tfba_back #(
    parameter int QUEUE_DEPTH = tfba_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tfba_pkg::t_cmd_word                 i_cmd,
    input  logic                                i_cmd_valid,
    output logic                                o_cmd_ready,
    input  logic [tfba_pkg::LIMIT_WIDTH-1:0]    i_limit,
    input  logic                                i_res_full,
    output logic                                o_res_valid,
    output tfba_pkg::t_out_word                 o_res,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]    o_urgent_count,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]    o_normal_count
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_C  = AW'(QUEUE_DEPTH - 1);

    typedef enum logic {
        S_FETCH,
        S_EXEC
    } t_state;

    t_state r_state;

    logic [tfba_pkg::TAG_WIDTH-1:0] r_urgent_mem [QUEUE_DEPTH];
    logic [tfba_pkg::TAG_WIDTH-1:0] r_normal_mem [QUEUE_DEPTH];

    logic [AW-1:0] r_u_head, r_u_tail, r_n_head, r_n_tail;
    logic [AW-1:0] n_u_head, n_u_tail, n_n_head, n_n_tail;
    logic [CW-1:0] r_u_count, r_n_count, n_u_count, n_n_count;
    logic [tfba_pkg::LIMIT_WIDTH-1:0] r_burst, n_burst;

    tfba_pkg::t_cmd_word            r_cmd;
    logic [tfba_pkg::TAG_WIDTH-1:0] r_u_rd;
    logic [tfba_pkg::TAG_WIDTH-1:0] r_n_rd;

    logic    w_take;
    logic    w_u_write;
    logic    w_n_write;
    logic    w_u_full;
    logic    w_n_full;
    logic [CW:0] w_sum;
    tfba_pkg::t_out_word w_res;

    // pointer wrap
    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] ptr);
        logic [AW-1:0] nxt;
        if (ptr == LAST_C) begin
            nxt = '0;
        end else begin
            nxt = ptr + 1'b1;
        end
        return nxt;
    endfunction

    assign w_take      = (r_state == S_FETCH) && i_cmd_valid && !i_res_full;
    assign o_cmd_ready = (r_state == S_FETCH) && !i_res_full;
    assign w_u_full    = (r_u_count == DEPTH_C);
    assign w_n_full    = (r_n_count == DEPTH_C);

    // execute the fetched command
    always_comb begin
        n_u_head  = r_u_head;
        n_u_tail  = r_u_tail;
        n_n_head  = r_n_head;
        n_n_tail  = r_n_tail;
        n_u_count = r_u_count;
        n_n_count = r_n_count;
        n_burst   = r_burst;
        w_u_write = 1'b0;
        w_n_write = 1'b0;
        w_res.status        = tfba_pkg::ST_NONE;
        w_res.served_tag    = '0;
        w_res.served_urgent = 1'b0;
        unique case (r_cmd.op)
            tfba_pkg::OP_ENQ_URGENT: begin
                if (w_u_full) begin
                    w_res.status = tfba_pkg::ST_DROPPED;
                end else begin
                    w_res.status = tfba_pkg::ST_ENQUEUED;
                    w_u_write    = 1'b1;
                    n_u_tail     = f_next(r_u_tail);
                    n_u_count    = r_u_count + 1'b1;
                end
            end
            tfba_pkg::OP_ENQ_NORMAL: begin
                if (w_n_full) begin
                    w_res.status = tfba_pkg::ST_DROPPED;
                end else begin
                    w_res.status = tfba_pkg::ST_ENQUEUED;
                    w_n_write    = 1'b1;
                    n_n_tail     = f_next(r_n_tail);
                    n_n_count    = r_n_count + 1'b1;
                end
            end
            tfba_pkg::OP_CALL: begin
                priority if (r_u_count == '0 && r_n_count == '0) begin
                    w_res.status = tfba_pkg::ST_NONE;
                end else if (r_burst < i_limit && r_u_count != '0) begin
                    w_res.status        = tfba_pkg::ST_SERVED;
                    w_res.served_tag    = r_u_rd;
                    w_res.served_urgent = 1'b1;
                    n_burst             = r_burst + 1'b1;
                    n_u_head            = f_next(r_u_head);
                    n_u_count           = r_u_count - 1'b1;
                end else if (r_n_count != '0) begin
                    w_res.status = tfba_pkg::ST_SERVED;
                    w_res.served_tag = r_n_rd;
                    n_burst      = tfba_pkg::LIMIT_WIDTH'(1);
                    n_n_head     = f_next(r_n_head);
                    n_n_count    = r_n_count - 1'b1;
                end else begin
                    // limit reached but no normal item waits
                    w_res.status        = tfba_pkg::ST_SERVED;
                    w_res.served_tag    = r_u_rd;
                    w_res.served_urgent = 1'b1;
                    n_u_head            = f_next(r_u_head);
                    n_u_count           = r_u_count - 1'b1;
                end
            end
            default: begin
                w_res.status = tfba_pkg::ST_NONE;
            end
        endcase
        w_sum               = {1'b0, n_u_count} + {1'b0, n_n_count};
        w_res.total_waiting = tfba_pkg::WAITING_WIDTH'(w_sum);
    end

    assign o_res_valid    = (r_state == S_EXEC);
    assign o_res          = w_res;
    assign o_urgent_count = r_u_count;
    assign o_normal_count = r_n_count;

    // sequencer and queue state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_FETCH;
            r_u_head  <= '0;
            r_u_tail  <= '0;
            r_n_head  <= '0;
            r_n_tail  <= '0;
            r_u_count <= '0;
            r_n_count <= '0;
            r_burst   <= '0;
        end else begin
            unique case (r_state)
                S_FETCH: begin
                    if (w_take) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state   <= S_FETCH;
                    r_u_head  <= n_u_head;
                    r_u_tail  <= n_u_tail;
                    r_n_head  <= n_n_head;
                    r_n_tail  <= n_n_tail;
                    r_u_count <= n_u_count;
                    r_n_count <= n_n_count;
                    r_burst   <= n_burst;
                end
                default: begin
                    r_state <= S_FETCH;
                end
            endcase
        end
    end

    // command capture and registered head reads
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd  <= i_cmd;
            r_u_rd <= r_urgent_mem[r_u_head];
            r_n_rd <= r_normal_mem[r_n_head];
        end
    end

    // store writes
    always_ff @(posedge i_clk) begin
        if (o_res_valid && w_u_write) begin
            r_urgent_mem[r_u_tail] <= r_cmd.tag;
        end
        if (o_res_valid && w_n_write) begin
            r_normal_mem[r_n_tail] <= r_cmd.tag;
        end
    end

endmodule

### hw/rtl/tfba_outq.sv
// two-entry result queue between the back end and the result ports
module tfba_outq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  tfba_pkg::t_out_word  i_res,
    output logic                 o_full,
    output logic                 empty,
    input  logic                 pop,
    output tfba_pkg::t_out_word  o_out
);

    tfba_pkg::t_out_word r_slot [2];
    logic                r_wr_ptr;
    logic                r_rd_ptr;
    logic [1:0]          r_count;
    logic [1:0]          n_count;
    logic                w_push;
    logic                w_pop;

    assign o_full = (r_count == 2'd2);
    assign empty  = (r_count == 2'd0);
    assign o_out  = r_slot[r_rd_ptr];
    assign w_push = i_push && !o_full;
    assign w_pop  = pop && !empty;

    // occupancy
    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (!w_push && w_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    // result slots
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_res;
        end
    end

endmodule

### hw/rtl/two_class_fifo_burst_arbiter.sv
// top level of the two-class fifo burst arbiter
// Queue-style block: push a word (enqueue a tag into the urgent or normal
// store, or call the next item) while full is low, and take one result word
// per input word while empty is low. The back end reads both store heads into
// registers, then arbitrates and updates the stores, and takes no new word
// until done with the last. A two-entry command queue and a two-entry result
// queue let the input and result sides stall on their own. The user must write
// the burst limit over the config channel (always ready) only while the block
// is idle; the block does not enforce this. The limit resets to 5.
module two_class_fifo_burst_arbiter #(
    parameter int QUEUE_DEPTH = tfba_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  tfba_pkg::t_in_word               i_in,
    output logic                             empty,
    input  logic                             pop,
    output tfba_pkg::t_out_word              o_out,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tfba_pkg::LIMIT_WIDTH-1:0] i_cfg_data
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    logic [tfba_pkg::LIMIT_WIDTH-1:0] r_limit;
    tfba_pkg::t_cmd_word              w_cmd;
    logic                             w_cmd_valid;
    logic                             w_cmd_ready;
    tfba_pkg::t_out_word              w_res;
    logic                             w_res_valid;
    logic                             w_res_full;
    logic [CW-1:0]                    w_u_count;
    logic [CW-1:0]                    w_n_count;

    // burst limit register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= tfba_pkg::LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_limit <= i_cfg_data;
        end
    end

    // front end
    tfba_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in        (i_in),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready)
    );

    // back end
    tfba_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_cmd_valid    (w_cmd_valid),
        .o_cmd_ready    (w_cmd_ready),
        .i_limit        (r_limit),
        .i_res_full     (w_res_full),
        .o_res_valid    (w_res_valid),
        .o_res          (w_res),
        .o_urgent_count (w_u_count),
        .o_normal_count (w_n_count)
    );

    // result queue
    tfba_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_res   (w_res),
        .o_full  (w_res_full),
        .empty   (empty),
        .pop     (pop),
        .o_out   (o_out)
    );

    // store occupancy never passes the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_u_count <= DEPTH_C) && (w_n_count <= DEPTH_C))
        else $error("store count above depth");

    // a result pushed while the result queue is full would be lost
    a_no_res_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> !w_res_full)
        else $error("result pushed into full queue");

    // only a served word carries a tag or the urgent flag
    a_zero_unless_served: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out.status != tfba_pkg::ST_SERVED) |->
            (o_out.served_tag == '0 && !o_out.served_urgent))
        else $error("tag on a word that was not served");

endmodule
